// ===== sv/secded_16_11_codec_defines.svh =====
// Assertion macros for the SECDED(16,11) codec checker.
`ifndef SECDED_16_11_CODEC_DEFINES_SVH
`define SECDED_16_11_CODEC_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define SCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("secded codec assertion failed");

// Clocked assertion that also holds during reset.
`define SCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("secded codec assertion failed");

`endif

// ===== sv/secded_pkg.sv =====
// Package: types, constants, bit-placement and syndrome functions of the SECDED(16,11) codec.
package secded_pkg;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_CORR = 2'd1,
    ST_DBL  = 2'd2
  } status_e;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Word bit of position 0; position p is bit 15-p.
  localparam logic [15:0] POS_MSB = 16'h8000;

  typedef struct packed {
    logic        mode;
    logic [15:0] word;
  } s1_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] word;
    logic [3:0]  syn;
    logic        par;
  } s2_t;

  typedef struct packed {
    logic [15:0] code;
    logic [10:0] data;
    status_e     status;
    logic [3:0]  syn;
  } s3_t;

  function automatic logic [15:0] place_data(input logic [10:0] d);
    logic [15:0] w;
    w        = '0;
    w[12]    = d[10];
    w[10:8]  = d[9:7];
    w[6:0]   = d[6:0];
    return w;
  endfunction

  function automatic logic [10:0] take_data(input logic [15:0] w);
    return {w[12], w[10:8], w[6:0]};
  endfunction

  // XOR of the positions of all set bits.
  function automatic logic [3:0] syndrome_of(input logic [15:0] w);
    logic [3:0] s;
    s = '0;
    for (int p = 0; p < 16; p++) begin
      if (w[15 - p]) s ^= 4'(p);
    end
    return s;
  endfunction

endpackage

// ===== sv/secded_16_11_codec.sv =====
// Top level: three-stage pipelined extended Hamming(16,11) SECDED encoder/decoder.
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_stall_o | mode_i, data_in_i, code_in_i
// out     | output    | out_valid_o / out_stall_i | code_out_o, data_out_o, status_o, syndrome_o
//
// A request passes through the stage registers s1, s2 and s3 to its result; one request
// per cycle is taken as long as the output is not stalled.
// The stages are: word build, syndrome and parity XOR trees, then correction
// or parity insertion with data extraction.
// Reset (rst_ni low, asynchronous) empties the pipeline; payload is not reset.
// A stall at the output fills empty stages first, so bubbles are squeezed out
// before in_stall_o rises; nothing is dropped or repeated.
module secded_16_11_codec
  import secded_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [10:0] data_in_i,
  input  logic [15:0] code_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_out_o,
  output logic [10:0] data_out_o,
  output logic [1:0]  status_o,
  output logic [3:0]  syndrome_o
);

  // Stage valid bits and payload registers.
  logic v1_q, v2_q, v3_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic en1, en2, en3;
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  // Stage 1: build the working word (placed data when encoding).
  always_comb begin
    s1_d.mode = mode_i;
    s1_d.word = (mode_i == MODE_DEC) ? code_in_i : place_data(data_in_i);
  end

  // Stage 2: syndrome and overall parity.
  always_comb begin
    s2_d.mode = s1_q.mode;
    s2_d.word = s1_q.word;
    s2_d.syn  = syndrome_of(s1_q.word);
    s2_d.par  = ^s1_q.word;
  end

  // Stage 3: insert parity bits (encode) or correct and classify (decode).
  always_comb begin
    logic [15:0] enc_w;
    logic [15:0] dec_w;
    enc_w      = s2_q.word;
    enc_w[14]  = s2_q.syn[0];
    enc_w[13]  = s2_q.syn[1];
    enc_w[11]  = s2_q.syn[2];
    enc_w[7]   = s2_q.syn[3];
    // overall parity covers the data plus the parity bits just set
    enc_w[15]  = s2_q.par ^ (^s2_q.syn);
    // odd parity: flip the position named by the syndrome (position 0 when zero)
    dec_w      = s2_q.par ? (s2_q.word ^ (POS_MSB >> s2_q.syn)) : s2_q.word;
    if (s2_q.mode == MODE_DEC) begin
      s3_d.code = dec_w;
      s3_d.data = take_data(dec_w);
      s3_d.syn  = s2_q.syn;
      if (s2_q.par) begin
        s3_d.status = ST_CORR;
      end else if (s2_q.syn != 4'd0) begin
        s3_d.status = ST_DBL;
      end else begin
        s3_d.status = ST_NONE;
      end
    end else begin
      s3_d.code   = enc_w;
      s3_d.data   = '0;
      s3_d.syn    = '0;
      s3_d.status = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign code_out_o  = s3_q.code;
  assign data_out_o  = s3_q.data;
  assign status_o    = s3_q.status;
  assign syndrome_o  = s3_q.syn;

endmodule

// ===== sv/secded_chk.sv =====
// Checker: port-level assertions for the SECDED codec, bound to the top level.
`include "secded_16_11_codec_defines.svh"

module secded_chk
  import secded_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] code_out_o,
  input logic [10:0] data_out_o,
  input logic [1:0]  status_o,
  input logic [3:0]  syndrome_o
);

  // Pipeline is empty while reset is held.
  `SCD_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o)

  // Only defined status codes leave the block.
  `SCD_ASSERT(a_status_code, clk_i, rst_ni, out_valid_o |-> (status_o == ST_NONE || status_o == ST_CORR || status_o == ST_DBL))

  // Clean words carry a zero syndrome; double errors never do.
  `SCD_ASSERT(a_status_syn, clk_i, rst_ni, (out_valid_o && status_o != ST_CORR) |-> ((status_o == ST_NONE) == (syndrome_o == 4'd0)))

  // A stalled result holds.
  `SCD_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(code_out_o) && $stable(data_out_o) && $stable(status_o)))

  // A waiting request is only held back by a full pipeline behind a stalled result.
  `SCD_ASSERT(a_in_stall, clk_i, rst_ni, (in_valid_i && in_stall_o) |-> (out_valid_o && out_stall_i))

endmodule

bind secded_16_11_codec secded_chk u_secded_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .code_out_o  (code_out_o),
  .data_out_o  (data_out_o),
  .status_o    (status_o),
  .syndrome_o  (syndrome_o)
);
